### hw/rtl/sliding_window_event_rate_macros.svh
// ----------------------------------------------------------------------------
// sliding window event rate: assertion macros
// shared assertion forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EVENT_RATE_MACROS_SVH
`define SLIDING_WINDOW_EVENT_RATE_MACROS_SVH

// same-cycle implication
`define SWER_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swer assertion failed");

// next-cycle implication
`define SWER_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swer assertion failed");

`endif

### hw/rtl/swer_pkg.sv
// ----------------------------------------------------------------------------
// swer_pkg
// types, sizes and ring index helpers of the sliding window event rate meter
// ----------------------------------------------------------------------------
`default_nettype none

package swer_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int COUNT_W    = $clog2(RING_DEPTH + 1);

  localparam int DATA_W     = 32;
  localparam int WIN_W      = 6;
  localparam logic [WIN_W-1:0] DEFAULT_WINDOW = WIN_W'(60);

  // one 32-bit register at byte address 0
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);

  typedef logic [RING_AW-1:0] slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [DATA_W-1:0] when_s;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] cls;
    logic [DATA_W-1:0] tmo;
  } reading_t;

  typedef struct packed {
    logic [DATA_W-1:0] now_seconds;
    logic [DATA_W-1:0] accept_total;
    logic [DATA_W-1:0] close_total;
    logic [DATA_W-1:0] timeout_total;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] accept_delta;
    logic [DATA_W-1:0] close_delta;
    logic [DATA_W-1:0] timeout_delta;
    logic [WIN_W-1:0]  span_seconds;
    logic              window_full;
  } out_t;

  function automatic slot_t slot_inc(input slot_t h);
    return (h == RING_AW'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  // head plus offset, wrapped once (offset never exceeds the depth)
  function automatic slot_t slot_add(input slot_t h, input count_t k);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W + 1)'(h) + (COUNT_W + 1)'(k);
    if (sum >= (COUNT_W + 1)'(RING_DEPTH)) begin
      sum = sum - (COUNT_W + 1)'(RING_DEPTH);
    end
    return sum[RING_AW-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/swer_if.sv
// ----------------------------------------------------------------------------
// swer channel interfaces
// valid/ready channels for sample items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface swer_in_if;
  import swer_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swer_out_if;
  import swer_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/swer_ram.sv
// ----------------------------------------------------------------------------
// swer_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module swer_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sliding_window_event_rate.sv
// ----------------------------------------------------------------------------
// sliding_window_event_rate
// windowed deltas of three event totals over a ring of timestamped readings
// ----------------------------------------------------------------------------
// Each sample item updates a time-ordered ring of readings held in one ram
// (same second replaces the newest, an earlier time clears the ring, else
// append), evicts readings older than now minus the window from the oldest
// end and returns newest-minus-oldest deltas, the span and a full flag. After
// acceptance an item passes a write of the ring ram, a read and a check of the
// oldest reading through the single ram read port (repeated for each reading
// evicted), a pass of the shared 32-bit subtractor for each of the four fields
// and a load of the output register. The result waits in that register while
// the next item is taken; a result still held there delays the next load until
// it is taken. No clearing pass follows reset; window_seconds resets to 60 and
// a written zero acts as 60.
`default_nettype none
`include "sliding_window_event_rate_macros.svh"

module sliding_window_event_rate (
  input  wire logic                            clk,
  input  wire logic                            rst,
  swer_in_if.sink                              sample,
  swer_out_if.source                           result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [swer_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);
  import swer_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_DIFF   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [1:0] F_WHEN = 2'd0;
  localparam logic [1:0] F_ACC  = 2'd1;
  localparam logic [1:0] F_CLS  = 2'd2;
  localparam logic [1:0] F_TMO  = 2'd3;

  logic [2:0]        state;
  logic [WIN_W-1:0]  window_seconds;
  logic [WIN_W-1:0]  win;
  in_t               smp;
  slot_t             head;
  count_t            count;
  slot_t             newest_slot;
  logic [DATA_W-1:0] newest_when;
  logic [DATA_W-1:0] bound;
  logic              early;
  logic [1:0]        idx;
  logic [DATA_W-1:0] d_when, d_acc, d_cls, d_tmo;
  logic              res_valid;
  out_t              res_data;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW) ? 32'(window_seconds) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= DEFAULT_WINDOW;
    end else if (cfg_wr && paddr[CFG_ADDR_W-1:2] == REG_WINDOW) begin
      window_seconds <= pwdata[WIN_W-1:0];
    end
  end

  // ring update decode
  logic   match, older;
  slot_t  h0, h1, wslot;
  count_t c0, c1;

  always_comb begin
    match = (count != '0) && (newest_when == smp.now_seconds);
    older = (count != '0) && (newest_when > smp.now_seconds);
    h0    = older ? '0 : head;
    c0    = older ? '0 : count;
    if (c0 == COUNT_W'(RING_DEPTH)) begin
      h1 = slot_inc(h0);
      c1 = c0 - 1'b1;
    end else begin
      h1 = h0;
      c1 = c0;
    end
    wslot = match ? newest_slot : slot_add(h1, c1);
  end

  // reading ram
  reading_t wr_rd, rd_rd;
  logic     ram_we, ram_re;

  assign wr_rd  = '{when_s: smp.now_seconds, acc: smp.accept_total,
                    cls: smp.close_total, tmo: smp.timeout_total};
  assign ram_we = (state == S_UPDATE);
  assign ram_re = (state == S_RD);

  swer_ram #(
    .WIDTH ($bits(reading_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot),
    .wdata (wr_rd),
    .re    (ram_re),
    .raddr (head),
    .rdata (rd_rd)
  );

  // shared subtractor, one field per cycle
  logic [DATA_W-1:0] sub_a, sub_b, sub_y;
  logic              evict;

  always_comb begin
    case (idx)
      F_WHEN:  begin sub_a = smp.now_seconds;   sub_b = rd_rd.when_s; end
      F_ACC:   begin sub_a = smp.accept_total;  sub_b = rd_rd.acc;    end
      F_CLS:   begin sub_a = smp.close_total;   sub_b = rd_rd.cls;    end
      F_TMO:   begin sub_a = smp.timeout_total; sub_b = rd_rd.tmo;    end
      default: begin sub_a = smp.now_seconds;   sub_b = rd_rd.when_s; end
    endcase
  end
  assign sub_y = sub_a - sub_b;

  assign evict = !early && (count > COUNT_W'(1)) && (rd_rd.when_s < bound);

  // result fields
  out_t done_data;
  always_comb begin
    done_data = '0;
    if (count >= COUNT_W'(2)) begin
      done_data.accept_delta  = d_acc;
      done_data.close_delta   = d_cls;
      done_data.timeout_delta = d_tmo;
      done_data.span_seconds  = d_when[WIN_W-1:0];
      done_data.window_full   = (d_when[DATA_W-1:WIN_W] != '0) ||
                                (d_when[WIN_W-1:0] >= win);
    end
  end

  logic res_load;
  assign res_load     = (state == S_DONE) && (!res_valid || result.ready);
  assign sample.ready = (state == S_IDLE) && !rst;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      idx       <= F_WHEN;
    end else begin
      if (res_valid && result.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            smp   <= sample.data;
            win   <= (window_seconds == '0) ? DEFAULT_WINDOW : window_seconds;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!match) begin
            head  <= h1;
            count <= c1 + 1'b1;
          end
          newest_slot <= wslot;
          newest_when <= smp.now_seconds;
          early       <= smp.now_seconds < DATA_W'(win);
          bound       <= smp.now_seconds - DATA_W'(win);
          state       <= S_RD;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (evict) begin
            head  <= slot_inc(head);
            count <= count - 1'b1;
            state <= S_RD;
          end else begin
            idx   <= F_WHEN;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          case (idx)
            F_WHEN:  d_when <= sub_y;
            F_ACC:   d_acc  <= sub_y;
            F_CLS:   d_cls  <= sub_y;
            F_TMO:   d_tmo  <= sub_y;
            default: d_when <= sub_y;
          endcase
          if (idx == F_TMO) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (res_load) begin
            res_valid <= 1'b1;
            res_data  <= done_data;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SWER_ASSERT_IMPL(a_count_range, 1'b1, count <= COUNT_W'(RING_DEPTH))
  `SWER_ASSERT_IMPL(a_head_range, 1'b1, head <= RING_AW'(RING_DEPTH - 1))
  `SWER_ASSERT_NEXT(a_accept_starts, sample.valid && sample.ready, state == S_UPDATE)
  `SWER_ASSERT_IMPL(a_ring_nonempty, state != S_IDLE && state != S_UPDATE, count != '0)

endmodule

`default_nettype wire

### dv/swer_rate_checker.sv
// ----------------------------------------------------------------------------
// swer_rate_checker
// watches the sample, result and register channels of the rate meter, keeps
// its own ring of readings and compares every result with the expected one
// ----------------------------------------------------------------------------
`default_nettype none

module swer_rate_checker
  import swer_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  swer_in_if                         sample,
  swer_out_if                        result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  input  wire logic                  pready,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int PEND_DEPTH = 16;

  reading_t         readings_mem [RING_DEPTH];
  int               oldest_slot;
  int               live_readings;
  logic [WIN_W-1:0] window_reg;
  out_t             pend_mem [PEND_DEPTH];
  int               pend_rd;
  int               pend_wr;
  int               errs;

  initial begin
    errs = 0;
    pend_rd = 0;
    pend_wr = 0;
  end

  function automatic int ring_slot(input int k);
    return (oldest_slot + k) % RING_DEPTH;
  endfunction

  function automatic out_t predict_rate(input in_t s);
    logic [31:0] win;
    logic [31:0] horizon;
    logic [31:0] span;
    int          newest;
    out_t        r;
    win = (window_reg == '0) ? 32'(DEFAULT_WINDOW) : 32'(window_reg);
    r = '0;
    newest = (live_readings != 0) ? ring_slot(live_readings - 1) : 0;
    if (live_readings != 0 && readings_mem[newest].when_s == s.now_seconds) begin
      // same second: only the totals of the newest reading change
      readings_mem[newest].acc = s.accept_total;
      readings_mem[newest].cls = s.close_total;
      readings_mem[newest].tmo = s.timeout_total;
    end else begin
      if (live_readings != 0 && readings_mem[newest].when_s > s.now_seconds) begin
        oldest_slot = 0;
        live_readings = 0;
      end
      if (live_readings >= RING_DEPTH) begin
        oldest_slot = ring_slot(1);
        live_readings--;
      end
      newest = ring_slot(live_readings);
      readings_mem[newest].when_s = s.now_seconds;
      readings_mem[newest].acc = s.accept_total;
      readings_mem[newest].cls = s.close_total;
      readings_mem[newest].tmo = s.timeout_total;
      live_readings++;
    end
    // no eviction while now is still below the window
    if (s.now_seconds >= win) begin
      horizon = s.now_seconds - win;
      while (live_readings > 1 && readings_mem[oldest_slot].when_s < horizon) begin
        oldest_slot = ring_slot(1);
        live_readings--;
      end
    end
    if (live_readings >= 2) begin
      newest = ring_slot(live_readings - 1);
      r.accept_delta = readings_mem[newest].acc - readings_mem[oldest_slot].acc;
      r.close_delta = readings_mem[newest].cls - readings_mem[oldest_slot].cls;
      r.timeout_delta = readings_mem[newest].tmo - readings_mem[oldest_slot].tmo;
      span = readings_mem[newest].when_s - readings_mem[oldest_slot].when_s;
      r.span_seconds = span[WIN_W-1:0];
      r.window_full = (span >= win);
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errs++;
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      oldest_slot = 0;
      live_readings = 0;
      window_reg = DEFAULT_WINDOW;
      pend_rd = 0;
      pend_wr = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (pend_wr == pend_rd) begin
          note_mismatch("result with nothing pending", '0, '0);
        end else begin
          want = pend_mem[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (result.data.accept_delta !== want.accept_delta) begin
            note_mismatch("accept_delta", result.data.accept_delta, want.accept_delta);
          end
          if (result.data.close_delta !== want.close_delta) begin
            note_mismatch("close_delta", result.data.close_delta, want.close_delta);
          end
          if (result.data.timeout_delta !== want.timeout_delta) begin
            note_mismatch("timeout_delta", result.data.timeout_delta, want.timeout_delta);
          end
          if (result.data.span_seconds !== want.span_seconds) begin
            note_mismatch("span_seconds", 32'(result.data.span_seconds),
                          32'(want.span_seconds));
          end
          if (result.data.window_full !== want.window_full) begin
            note_mismatch("window_full", 32'(result.data.window_full),
                          32'(want.window_full));
          end
        end
      end
      if (sample.valid && sample.ready) begin
        if (pend_wr - pend_rd >= PEND_DEPTH) begin
          note_mismatch("too many items pending", '0, '0);
        end else begin
          pend_mem[pend_wr % PEND_DEPTH] = predict_rate(sample.data);
          pend_wr++;
        end
      end
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_WINDOW) begin
        window_reg = pwdata[WIN_W-1:0];
      end
    end
    outstanding <= pend_wr - pend_rd;
    mismatches <= errs;
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// directed and random samples for the sliding window event rate meter
// ----------------------------------------------------------------------------
// A short directed run walks the window edges, same-second replacement, ring
// clearing on an earlier time and early times, then random phases under
// several window settings feed runs of steadily ticking samples broken up by
// jumps, rewinds, rebases and noise. The checker predicts every result.
`default_nettype none

module tb_top;
  import swer_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int PHASE_LEN  = 190;
  localparam int HOLD_LEN   = 300;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = CFG_ADDR_W'(int'(REG_WINDOW) * 4);

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  swer_in_if  smp ();
  swer_out_if res ();

  int fail_count;
  int pending;
  int cycles;
  bit idling;
  bit hold_req;

  logic [31:0] t_now;
  logic [31:0] acc_run;
  logic [31:0] cls_run;
  logic [31:0] tmo_run;

  sliding_window_event_rate DUT (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swer_rate_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .sample      (smp),
    .result      (res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (fail_count),
    .outstanding (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (stall > 0) begin
        res.ready <= 1'b0;
        stall--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // called right after a rising edge; returns at the edge that takes the item
  task automatic offer(input logic [31:0] now, input logic [31:0] a,
                       input logic [31:0] c, input logic [31:0] t);
    int  gap;
    in_t item;
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
    end
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.now_seconds = now;
    item.accept_total = a;
    item.close_total = c;
    item.timeout_total = t;
    smp.valid <= 1'b1;
    smp.data <= item;
    do @(negedge clk); while (!smp.ready);
    @(posedge clk);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one item that breaks a steady run
  task automatic disrupt();
    case ($urandom_range(0, 3))
      0: t_now = t_now + 32'($urandom_range(2, 130));
      1: t_now = t_now - 32'($urandom_range(1, 50));
      2: begin
        case ($urandom_range(0, 2))
          0: t_now = $urandom();
          1: t_now = 32'($urandom_range(0, 70));
          default: t_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 100));
        endcase
      end
      default: begin
        t_now = t_now + 32'($urandom_range(0, 1));
        acc_run = $urandom();
        cls_run = $urandom();
        tmo_run = $urandom();
      end
    endcase
    offer(t_now, acc_run, cls_run, tmo_run);
  endtask

  task automatic run_phase(input int n);
    int sent;
    int run_len;
    bit dense;
    int step_pick;
    sent = 0;
    while (sent < n) begin
      run_len = $urandom_range(4, 90);
      dense = $urandom_range(0, 1);
      while (run_len > 0 && sent < n) begin
        step_pick = $urandom_range(0, 9);
        // dense runs never skip a second so a wide window fills the ring
        if (step_pick == 0) begin
          t_now = t_now;
        end else if (dense || step_pick < 9) begin
          t_now = t_now + 32'd1;
        end else begin
          t_now = t_now + 32'd2;
        end
        acc_run = acc_run + 32'($urandom_range(0, 400));
        cls_run = cls_run + 32'($urandom_range(0, 400));
        tmo_run = tmo_run + 32'($urandom_range(0, 20));
        offer(t_now, acc_run, cls_run, tmo_run);
        sent++;
        run_len--;
      end
      if (sent < n) begin
        disrupt();
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    smp.valid = 1'b0;
    smp.data = '0;
    idling = 1'b1;
    hold_req = 1'b0;
    t_now = '0;
    acc_run = '0;
    cls_run = '0;
    tmo_run = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default window of 60
    offer(32'd0, 32'd0, 32'd0, 32'd0);
    offer(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'd1, 32'd5, 32'd5, 32'd5);
    offer(32'd59, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    offer(32'd60, 32'h8000_0001, 32'h8000_0000, 32'd2);
    offer(32'd61, 32'h8000_0002, 32'h8000_0001, 32'd3);
    offer(32'd200, 32'd7, 32'd8, 32'd9);
    offer(32'd100, 32'd1, 32'd2, 32'd3);
    offer(32'hFFFF_FFC3, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    offer(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
    offer(32'hFFFF_FFC0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    offer(32'd0, 32'd10, 32'd20, 32'd30);
    drain();

    // smallest window
    write_window(32'd1);
    offer(32'd0, 32'd1, 32'd1, 32'd1);
    offer(32'd1, 32'd2, 32'd3, 32'd4);
    offer(32'd2, 32'd4, 32'd6, 32'd8);
    offer(32'd2, 32'd9, 32'd9, 32'd9);
    drain();

    // zero falls back to sixty seconds
    write_window(32'd0);
    offer(32'd100, 32'd0, 32'd0, 32'd0);
    offer(32'd130, 32'd3, 32'd2, 32'd1);
    offer(32'd161, 32'd6, 32'd4, 32'd2);
    drain();

    // widest window
    write_window(32'd63);
    offer(32'd10, 32'd100, 32'd200, 32'd300);
    offer(32'd73, 32'd50, 32'd60, 32'd70);
    offer(32'd74, 32'd51, 32'd61, 32'd71);
    drain();

    t_now = 32'd1000;
    run_phase(PHASE_LEN);
    drain();

    write_window(32'd1);
    hold_req <= 1'b1;
    run_phase(PHASE_LEN);
    drain();

    write_window(32'd0);
    run_phase(PHASE_LEN);
    drain();

    write_window(32'($urandom_range(1, 63)));
    run_phase(PHASE_LEN);
    drain();

    write_window(32'd63);
    run_phase(PHASE_LEN);
    drain();

    // closing phase runs with no idling on either side
    idling <= 1'b0;
    write_window(32'($urandom_range(1, 63)));
    run_phase(PHASE_LEN);
    drain();
    repeat (16) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/swer_pkg.sv
hw/rtl/swer_if.sv
hw/rtl/swer_ram.sv
hw/rtl/sliding_window_event_rate.sv
dv/swer_rate_checker.sv
dv/tb_top.sv
